// ===== src/clts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clts_pkg: shared constants and helper functions of the token scanner
// Scan modes, token kinds, whitespace character codes and the byte-class
// functions used by the scanner.
// ----------------------------------------------------------------------------
package clts_pkg;

    localparam int MODE_BITS = 6;

    // Modes 0..29 mean a token of that kind is pending (29: delimiter).
    localparam logic [5:0] MODE_DELIM = 6'd29;
    localparam logic [5:0] MODE_START = 6'd30;
    localparam logic [5:0] MODE_DOT   = 6'd31;
    localparam logic [5:0] MODE_STR   = 6'd32;
    localparam logic [5:0] MODE_ESC   = 6'd33;
    localparam logic [5:0] MODE_LCOM  = 6'd34;
    localparam logic [5:0] MODE_BCOM  = 6'd35;
    localparam logic [5:0] MODE_BSTAR = 6'd36;
    localparam logic [5:0] MODE_AMP   = 6'd37;
    localparam logic [5:0] MODE_PIPE  = 6'd38;

    localparam logic [5:0] KIND_IDENT  = 6'd0;
    localparam logic [5:0] KIND_INT    = 6'd1;
    localparam logic [5:0] KIND_FLOAT  = 6'd2;
    localparam logic [5:0] KIND_STRING = 6'd3;
    localparam logic [5:0] KIND_ERROR  = 6'd4;
    localparam logic [5:0] KIND_PLUS   = 6'd5;
    localparam logic [5:0] KIND_MINUS  = 6'd6;
    localparam logic [5:0] KIND_INC    = 6'd7;
    localparam logic [5:0] KIND_DEC    = 6'd8;
    localparam logic [5:0] KIND_STAR   = 6'd9;
    localparam logic [5:0] KIND_SLASH  = 6'd10;
    localparam logic [5:0] KIND_PCT    = 6'd11;
    localparam logic [5:0] KIND_ASSIGN = 6'd12;
    localparam logic [5:0] KIND_NOT    = 6'd13;
    localparam logic [5:0] KIND_ADDEQ  = 6'd14;
    localparam logic [5:0] KIND_SUBEQ  = 6'd15;
    localparam logic [5:0] KIND_MULEQ  = 6'd16;
    localparam logic [5:0] KIND_DIVEQ  = 6'd17;
    localparam logic [5:0] KIND_MODEQ  = 6'd18;
    localparam logic [5:0] KIND_EQ     = 6'd19;
    localparam logic [5:0] KIND_NE     = 6'd20;
    localparam logic [5:0] KIND_GT     = 6'd21;
    localparam logic [5:0] KIND_LT     = 6'd22;
    localparam logic [5:0] KIND_GE     = 6'd23;
    localparam logic [5:0] KIND_LE     = 6'd24;
    localparam logic [5:0] KIND_AND    = 6'd25;
    localparam logic [5:0] KIND_OR     = 6'd26;
    localparam logic [5:0] KIND_QUEST  = 6'd27;
    localparam logic [5:0] KIND_COLON  = 6'd28;
    localparam logic [5:0] KIND_END    = 6'd37;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return is_digit(c) || is_alpha(c);
    endfunction

endpackage

// ===== src/clts_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clts_front: byte classifier and scanner state
// Advances the lexer state by one byte a beat and issues up to two result
// records (pending token, end marker) into the queue.
// ----------------------------------------------------------------------------
module clts_front #(
    parameter int LINE_BITS   = 16,
    parameter int COLUMN_BITS = 12,
    parameter int LENGTH_BITS = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_fire,
    input  logic [7:0]             i_ch,
    input  logic                   i_eoi,
    output logic                   o_tok_valid,
    output logic [5:0]             o_tok_kind,
    output logic [LINE_BITS-1:0]   o_tok_line,
    output logic [COLUMN_BITS-1:0] o_tok_col,
    output logic [LENGTH_BITS-1:0] o_tok_len,
    output logic                   o_end_valid,
    output logic [LINE_BITS-1:0]   o_end_line,
    output logic [COLUMN_BITS-1:0] o_end_col
);

    localparam logic [LINE_BITS-1:0]   LineMax = {LINE_BITS{1'b1}};
    localparam logic [COLUMN_BITS-1:0] ColMax  = {COLUMN_BITS{1'b1}};
    localparam logic [LENGTH_BITS-1:0] LenMax  = {LENGTH_BITS{1'b1}};
    localparam logic [LENGTH_BITS-1:0] LenOne  = {{(LENGTH_BITS-1){1'b0}}, 1'b1};

    logic [5:0]             r_mode, n_mode;
    logic [LINE_BITS-1:0]   r_line, n_line;
    logic [COLUMN_BITS-1:0] r_col, n_col;
    logic [LINE_BITS-1:0]   r_tline, n_tline;
    logic [COLUMN_BITS-1:0] r_tcol, n_tcol;
    logic [LENGTH_BITS-1:0] r_len, n_len;
    logic                   r_alnum, n_alnum;
    logic [2:0]             r_dcode, n_dcode;

    logic [COLUMN_BITS-1:0] col;
    logic [LENGTH_BITS-1:0] len_inc;
    logic [5:0]             pend_kind;
    logic [5:0]             op_next;
    logic                   restart;
    logic                   c_alnum;

    assign col       = (r_col == ColMax) ? ColMax : r_col + 1'b1;
    assign len_inc   = (r_len == LenMax) ? LenMax : r_len + 1'b1;
    assign pend_kind = (r_mode == clts_pkg::MODE_DELIM) ?
                       6'(clts_pkg::MODE_DELIM + {3'd0, r_dcode}) : r_mode;
    assign c_alnum   = clts_pkg::is_alnum(i_ch);

    always_comb begin
        op_next = clts_pkg::KIND_IDENT;
        case (r_mode)
            clts_pkg::KIND_PLUS:   op_next = (i_ch == "+") ? clts_pkg::KIND_INC :
                                             (i_ch == "=") ? clts_pkg::KIND_ADDEQ :
                                             clts_pkg::KIND_IDENT;
            clts_pkg::KIND_MINUS:  op_next = (i_ch == "-") ? clts_pkg::KIND_DEC :
                                             (i_ch == "=") ? clts_pkg::KIND_SUBEQ :
                                             clts_pkg::KIND_IDENT;
            clts_pkg::KIND_STAR:   op_next = (i_ch == "=") ? clts_pkg::KIND_MULEQ
                                                           : clts_pkg::KIND_IDENT;
            clts_pkg::KIND_SLASH:  op_next = (i_ch == "=") ? clts_pkg::KIND_DIVEQ
                                                           : clts_pkg::KIND_IDENT;
            clts_pkg::KIND_PCT:    op_next = (i_ch == "=") ? clts_pkg::KIND_MODEQ
                                                           : clts_pkg::KIND_IDENT;
            clts_pkg::KIND_ASSIGN: op_next = (i_ch == "=") ? clts_pkg::KIND_EQ
                                                           : clts_pkg::KIND_IDENT;
            clts_pkg::KIND_NOT:    op_next = (i_ch == "=") ? clts_pkg::KIND_NE
                                                           : clts_pkg::KIND_IDENT;
            clts_pkg::KIND_GT:     op_next = (i_ch == "=") ? clts_pkg::KIND_GE
                                                           : clts_pkg::KIND_IDENT;
            clts_pkg::KIND_LT:     op_next = (i_ch == "=") ? clts_pkg::KIND_LE
                                                           : clts_pkg::KIND_IDENT;
            default:               op_next = clts_pkg::KIND_IDENT;
        endcase
    end

    always_comb begin
        n_mode  = r_mode;
        n_line  = r_line;
        n_col   = r_col;
        n_tline = r_tline;
        n_tcol  = r_tcol;
        n_len   = r_len;
        n_alnum = r_alnum;
        n_dcode = r_dcode;
        restart = 1'b0;
        o_tok_valid = 1'b0;
        o_tok_kind  = pend_kind;
        o_tok_len   = r_len;
        o_end_valid = 1'b0;

        if (i_eoi) begin
            if (r_mode <= clts_pkg::MODE_DELIM) begin
                o_tok_valid = 1'b1;
            end else if (r_mode == clts_pkg::MODE_DOT || r_mode == clts_pkg::MODE_AMP ||
                         r_mode == clts_pkg::MODE_PIPE) begin
                o_tok_valid = 1'b1;
                o_tok_kind  = clts_pkg::KIND_ERROR;
            end else if (r_mode == clts_pkg::MODE_STR || r_mode == clts_pkg::MODE_ESC) begin
                o_tok_valid = 1'b1;
                o_tok_kind  = clts_pkg::KIND_ERROR;
                o_tok_len   = len_inc;
            end
            o_end_valid = 1'b1;
            n_mode  = clts_pkg::MODE_START;
            n_line  = {{(LINE_BITS-1){1'b0}}, 1'b1};
            n_col   = '0;
            n_tline = {{(LINE_BITS-1){1'b0}}, 1'b1};
            n_tcol  = {{(COLUMN_BITS-1){1'b0}}, 1'b1};
            n_len   = '0;
            n_alnum = 1'b0;
            n_dcode = 3'd0;
        end else begin
            case (r_mode)
                clts_pkg::MODE_START: restart = 1'b1;
                clts_pkg::KIND_IDENT: begin
                    if (c_alnum || i_ch == "_") begin
                        n_len = len_inc; n_alnum = c_alnum;
                    end else begin
                        restart = 1'b1;
                    end
                end
                clts_pkg::KIND_INT, clts_pkg::KIND_FLOAT: begin
                    if (clts_pkg::is_digit(i_ch)) begin
                        n_len = len_inc; n_alnum = 1'b1;
                    end else if (i_ch == "." && r_mode == clts_pkg::KIND_INT) begin
                        n_len = len_inc; n_alnum = 1'b0; n_mode = clts_pkg::MODE_DOT;
                    end else if (clts_pkg::is_alpha(i_ch)) begin
                        n_len = len_inc; n_alnum = 1'b1; n_mode = clts_pkg::KIND_ERROR;
                    end else begin
                        restart = 1'b1;
                    end
                end
                clts_pkg::MODE_DOT: begin
                    n_len = len_inc; n_alnum = c_alnum;
                    n_mode = clts_pkg::is_digit(i_ch) ? clts_pkg::KIND_FLOAT
                                                      : clts_pkg::KIND_ERROR;
                end
                clts_pkg::MODE_AMP: begin
                    n_len = len_inc; n_alnum = c_alnum;
                    n_mode = (i_ch == "&") ? clts_pkg::KIND_AND : clts_pkg::KIND_ERROR;
                end
                clts_pkg::MODE_PIPE: begin
                    n_len = len_inc; n_alnum = c_alnum;
                    n_mode = (i_ch == "|") ? clts_pkg::KIND_OR : clts_pkg::KIND_ERROR;
                end
                clts_pkg::MODE_STR: begin
                    if (i_ch == "\"") begin
                        n_mode = clts_pkg::KIND_STRING;
                    end else if (i_ch == "\\") begin
                        n_mode = clts_pkg::MODE_ESC;
                    end else if (i_ch == clts_pkg::CH_LF) begin
                        n_len = len_inc; n_mode = clts_pkg::KIND_ERROR;
                    end else begin
                        n_len = len_inc; n_alnum = c_alnum;
                    end
                end
                clts_pkg::MODE_ESC: begin
                    n_alnum = 1'b0;
                    if (i_ch == "a" || i_ch == "b" || i_ch == "f" || i_ch == "n" ||
                        i_ch == "r" || i_ch == "t" || i_ch == "v" || i_ch == "'" ||
                        i_ch == "\"" || i_ch == "\\") begin
                        n_len = len_inc; n_mode = clts_pkg::MODE_STR;
                    end else begin
                        n_len = '0; n_mode = clts_pkg::KIND_ERROR;
                    end
                end
                clts_pkg::MODE_LCOM: begin
                    if (i_ch == clts_pkg::CH_LF) n_mode = clts_pkg::MODE_START;
                end
                clts_pkg::MODE_BCOM: begin
                    if (i_ch == "*") n_mode = clts_pkg::MODE_BSTAR;
                end
                clts_pkg::MODE_BSTAR: begin
                    if (i_ch == "/") n_mode = clts_pkg::MODE_START;
                    else if (i_ch != "*") n_mode = clts_pkg::MODE_BCOM;
                end
                clts_pkg::KIND_ERROR: begin
                    if (r_alnum && c_alnum) begin
                        n_len = len_inc; n_alnum = 1'b1;
                    end else begin
                        restart = 1'b1;
                    end
                end
                default: begin
                    if (r_mode == clts_pkg::KIND_SLASH && i_ch == "/") begin
                        n_mode = clts_pkg::MODE_LCOM;
                    end else if (r_mode == clts_pkg::KIND_SLASH && i_ch == "*") begin
                        n_mode = clts_pkg::MODE_BCOM;
                    end else if (r_mode > clts_pkg::MODE_DELIM ||
                                 op_next == clts_pkg::KIND_IDENT) begin
                        restart = 1'b1;
                    end else begin
                        n_mode = op_next; n_len = len_inc; n_alnum = c_alnum;
                    end
                end
            endcase

            if (restart) begin
                o_tok_valid = (r_mode <= clts_pkg::MODE_DELIM);
                n_mode = clts_pkg::MODE_START;
                if (!(i_ch == clts_pkg::CH_SPACE || i_ch == clts_pkg::CH_TAB ||
                      i_ch == clts_pkg::CH_CR || i_ch == clts_pkg::CH_LF)) begin
                    n_tline = r_line;
                    n_tcol  = col;
                    n_len   = LenOne;
                    n_alnum = 1'b0;
                    if (clts_pkg::is_alpha(i_ch) || i_ch == "_") begin
                        n_mode = clts_pkg::KIND_IDENT;
                    end else if (clts_pkg::is_digit(i_ch)) begin
                        n_mode = clts_pkg::KIND_INT;
                    end else begin
                        case (i_ch)
                            "+": n_mode = clts_pkg::KIND_PLUS;
                            "-": n_mode = clts_pkg::KIND_MINUS;
                            "*": n_mode = clts_pkg::KIND_STAR;
                            "/": n_mode = clts_pkg::KIND_SLASH;
                            "%": n_mode = clts_pkg::KIND_PCT;
                            "=": n_mode = clts_pkg::KIND_ASSIGN;
                            "!": n_mode = clts_pkg::KIND_NOT;
                            ">": n_mode = clts_pkg::KIND_GT;
                            "<": n_mode = clts_pkg::KIND_LT;
                            "?": n_mode = clts_pkg::KIND_QUEST;
                            ":": n_mode = clts_pkg::KIND_COLON;
                            "&": n_mode = clts_pkg::MODE_AMP;
                            "|": n_mode = clts_pkg::MODE_PIPE;
                            "\"": begin n_mode = clts_pkg::MODE_STR; n_len = '0; end
                            "(": begin n_mode = clts_pkg::MODE_DELIM; n_dcode = 3'd0; end
                            ")": begin n_mode = clts_pkg::MODE_DELIM; n_dcode = 3'd1; end
                            "[": begin n_mode = clts_pkg::MODE_DELIM; n_dcode = 3'd2; end
                            "]": begin n_mode = clts_pkg::MODE_DELIM; n_dcode = 3'd3; end
                            "{": begin n_mode = clts_pkg::MODE_DELIM; n_dcode = 3'd4; end
                            "}": begin n_mode = clts_pkg::MODE_DELIM; n_dcode = 3'd5; end
                            ";": begin n_mode = clts_pkg::MODE_DELIM; n_dcode = 3'd6; end
                            ",": begin n_mode = clts_pkg::MODE_DELIM; n_dcode = 3'd7; end
                            default: n_mode = clts_pkg::KIND_ERROR;
                        endcase
                    end
                end
            end

            if (i_ch == clts_pkg::CH_LF) begin
                n_line = (r_line == LineMax) ? LineMax : r_line + 1'b1;
                n_col  = '0;
            end else begin
                n_col = col;
            end
        end
    end

    assign o_tok_line = r_tline;
    assign o_tok_col  = r_tcol;
    assign o_end_line = r_line;
    assign o_end_col  = col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= clts_pkg::MODE_START;
            r_line  <= {{(LINE_BITS-1){1'b0}}, 1'b1};
            r_col   <= '0;
            r_tline <= {{(LINE_BITS-1){1'b0}}, 1'b1};
            r_tcol  <= {{(COLUMN_BITS-1){1'b0}}, 1'b1};
            r_len   <= '0;
            r_alnum <= 1'b0;
            r_dcode <= 3'd0;
        end else if (i_fire) begin
            r_mode  <= n_mode;
            r_line  <= n_line;
            r_col   <= n_col;
            r_tline <= n_tline;
            r_tcol  <= n_tcol;
            r_len   <= n_len;
            r_alnum <= n_alnum;
            r_dcode <= n_dcode;
        end
    end

endmodule

// ===== src/clts_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clts_queue: result queue and output stage
// Four-entry queue that takes up to two records a cycle and gives one beat a
// cycle to the output side while i_ready is high.
// ----------------------------------------------------------------------------
module clts_queue #(
    parameter int WIDTH = 43
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr0,
    input  logic [WIDTH-1:0] i_d0,
    input  logic             i_wr1,
    input  logic [WIDTH-1:0] i_d1,
    output logic             o_room,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data,
    input  logic             i_ready
);

    logic [WIDTH-1:0] r_mem [4];
    logic [1:0]       r_rd, r_wr;
    logic [2:0]       r_cnt, n_cnt;
    logic             pop;
    logic [1:0]       wr_b;

    assign pop     = o_valid && i_ready;
    assign o_valid = (r_cnt != 3'd0);
    assign o_data  = r_mem[r_rd];
    // Two free places are needed for the worst beat, counted before the pop.
    assign o_room  = (r_cnt <= 3'd2);
    assign wr_b    = i_wr0 ? 2'(r_wr + 2'd1) : r_wr;
    assign n_cnt   = 3'(r_cnt + {2'd0, i_wr0} + {2'd0, i_wr1} - {2'd0, pop});

    always_ff @(posedge i_clk) begin
        if (i_wr0) r_mem[r_wr] <= i_d0;
        if (i_wr1) r_mem[wr_b] <= i_d1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= 2'd0;
            r_wr  <= 2'd0;
            r_cnt <= 3'd0;
        end else begin
            if (pop) r_rd <= 2'(r_rd + 2'd1);
            r_wr  <= 2'(r_wr + {1'b0, i_wr0} + {1'b0, i_wr1});
            r_cnt <= n_cnt;
        end
    end

endmodule

// ===== src/c_like_token_scanner_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c_like_token_scanner_core: byte-stream lexer for a small C-like language
// One source byte a beat in; token records out.
//
//  channel | dir | tdata (low bit up)                     | tuser / tlast
//  s_axis  | in  | ch[7:0]                                | tuser: end_of_input
//  m_axis  | out | start_line, start_column, lexeme_length| tuser: token_kind, tlast
//
// One byte is taken each cycle while the result queue has two free places.
// A token is written to the result queue when the byte that ends it is taken.
// End of input gives up to two beats, drained one a cycle while m_axis_tready is high.
// Reset clears the scanner and the queue.
// ----------------------------------------------------------------------------
module c_like_token_scanner_core #(
    parameter int LINE_BITS   = 16,
    parameter int COLUMN_BITS = 12,
    parameter int LENGTH_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // ch
    input  logic        s_axis_tuser,   // end_of_input
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // start_line, start_column, lexeme_length, zero fill
    output logic [((LINE_BITS+COLUMN_BITS+LENGTH_BITS+7)/8)*8-1:0] m_axis_tdata,
    output logic [5:0]  m_axis_tuser,   // token_kind
    output logic        m_axis_tlast
);

    localparam int PayW = LINE_BITS + COLUMN_BITS + LENGTH_BITS;
    localparam int TdW  = ((PayW + 7) / 8) * 8;
    localparam int RecW = PayW + 7;

    logic                   fire, room;
    logic                   tok_v, end_v;
    logic [5:0]             tok_kind;
    logic [LINE_BITS-1:0]   tok_line, end_line;
    logic [COLUMN_BITS-1:0] tok_col, end_col;
    logic [LENGTH_BITS-1:0] tok_len;
    logic [RecW-1:0]        d0, d1, q;
    logic                   w0, w1;

    assign s_axis_tready = room;
    assign fire = s_axis_tvalid && room;

    clts_front #(
        .LINE_BITS(LINE_BITS), .COLUMN_BITS(COLUMN_BITS), .LENGTH_BITS(LENGTH_BITS)
    ) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_fire(fire),
        .i_ch(s_axis_tdata), .i_eoi(s_axis_tuser),
        .o_tok_valid(tok_v), .o_tok_kind(tok_kind), .o_tok_line(tok_line),
        .o_tok_col(tok_col), .o_tok_len(tok_len),
        .o_end_valid(end_v), .o_end_line(end_line), .o_end_col(end_col)
    );

    // Record: {last, kind, length, column, line}
    assign d0 = {1'b0, tok_kind, tok_len, tok_col, tok_line};
    assign d1 = {1'b1, clts_pkg::KIND_END, {LENGTH_BITS{1'b0}}, end_col, end_line};

    // When no token goes, the end marker takes the first slot.
    assign w0 = fire && (tok_v || end_v);
    assign w1 = fire && tok_v && end_v;

    clts_queue #(.WIDTH(RecW)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_wr0(w0), .i_d0(tok_v ? d0 : d1),
        .i_wr1(w1), .i_d1(d1),
        .o_room(room), .o_valid(m_axis_tvalid), .o_data(q), .i_ready(m_axis_tready)
    );

    assign m_axis_tdata = TdW'(q[PayW-1:0]);
    assign m_axis_tuser = q[PayW+5:PayW];
    assign m_axis_tlast = q[RecW-1];

endmodule

// ===== src/clts_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clts_checker: port-level checks for the token scanner
// Watches the stream ports of the top level; attached by bind.
// ----------------------------------------------------------------------------
module clts_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [5:0] m_axis_tuser,
    input logic       m_axis_tlast
);

    // The end marker and only it carries tlast.
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == clts_pkg::KIND_END)))
        else $error("tlast does not match end kind");

    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser <= clts_pkg::KIND_END))
        else $error("token kind out of range");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("output beat dropped");

    // Straight after reset nothing is offered and the input side is open.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!m_axis_tvalid && s_axis_tready))
        else $error("wrong handshake state after reset");

endmodule

bind c_like_token_scanner_core clts_checker u_clts_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tuser(m_axis_tuser), .m_axis_tlast(m_axis_tlast)
);

// ===== tb/c_like_token_scanner_core_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c_like_token_scanner_core_checker: scoreboard for the token scanner
// Watches both streams, predicts the token records of every accepted input
// beat with a behavioural lexer, and compares each output beat with the
// oldest prediction, field by field.
// ----------------------------------------------------------------------------
module c_like_token_scanner_core_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // ch
    input  logic        s_axis_tuser,   // end_of_input
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [39:0] m_axis_tdata,   // start_line, start_column, lexeme_length
    input  logic [5:0]  m_axis_tuser,   // token_kind
    input  logic        m_axis_tlast,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [5:0]  kind;
        logic [15:0] line;
        logic [11:0] column;
        logic [7:0]  length;
        logic        last;
    } t_token;

    t_token tokens_due[$];

    logic [5:0]  mode;
    logic [15:0] cur_line;
    logic [11:0] cur_col;
    logic [15:0] tok_line;
    logic [11:0] tok_col;
    logic [7:0]  tok_len;
    logic        tail_alnum;
    logic [2:0]  delim_sel;

    function automatic logic [7:0] len_inc(input logic [7:0] v);
        return (v == 8'hFF) ? v : v + 8'd1;
    endfunction

    function automatic logic alnum(input logic [7:0] c);
        return ((c >= "0") && (c <= "9")) || ((c >= "a") && (c <= "z"))
            || ((c >= "A") && (c <= "Z"));
    endfunction

    function automatic logic digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    task automatic lexer_clear();
        mode = clts_pkg::MODE_START; cur_line = 16'd1; cur_col = '0; tok_line = 16'd1;
        tok_col = 12'd1; tok_len = '0; tail_alnum = 1'b0; delim_sel = '0;
    endtask

    task automatic emit(input logic [5:0] k, input logic [15:0] l, input logic [11:0] c,
                        input logic [7:0] n, input logic lst);
        t_token t;
        t.kind = k; t.line = l; t.column = c; t.length = n; t.last = lst;
        tokens_due.push_back(t);
    endtask

    task automatic take_byte(input logic [7:0] c);
        tok_len = len_inc(tok_len);
        tail_alnum = alnum(c);
    endtask

    // Opens a new token with the byte that ended the previous one.
    task automatic open_token(input logic [7:0] c, input logic [11:0] col);
        mode = clts_pkg::MODE_START;
        if (c == clts_pkg::CH_SPACE || c == clts_pkg::CH_TAB || c == clts_pkg::CH_CR
            || c == clts_pkg::CH_LF) return;
        tok_line = cur_line; tok_col = col; tok_len = 8'd1; tail_alnum = 1'b0;
        if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_")
            mode = clts_pkg::KIND_IDENT;
        else if (digit(c)) mode = clts_pkg::KIND_INT;
        else case (c)
            "+": mode = clts_pkg::KIND_PLUS;
            "-": mode = clts_pkg::KIND_MINUS;
            "*": mode = clts_pkg::KIND_STAR;
            "/": mode = clts_pkg::KIND_SLASH;
            "%": mode = clts_pkg::KIND_PCT;
            "=": mode = clts_pkg::KIND_ASSIGN;
            "!": mode = clts_pkg::KIND_NOT;
            ">": mode = clts_pkg::KIND_GT;
            "<": mode = clts_pkg::KIND_LT;
            "?": mode = clts_pkg::KIND_QUEST;
            ":": mode = clts_pkg::KIND_COLON;
            "&": mode = clts_pkg::MODE_AMP;
            "|": mode = clts_pkg::MODE_PIPE;
            "\"": begin mode = clts_pkg::MODE_STR; tok_len = '0; end
            "(": begin mode = clts_pkg::MODE_DELIM; delim_sel = 3'd0; end
            ")": begin mode = clts_pkg::MODE_DELIM; delim_sel = 3'd1; end
            "[": begin mode = clts_pkg::MODE_DELIM; delim_sel = 3'd2; end
            "]": begin mode = clts_pkg::MODE_DELIM; delim_sel = 3'd3; end
            "{": begin mode = clts_pkg::MODE_DELIM; delim_sel = 3'd4; end
            "}": begin mode = clts_pkg::MODE_DELIM; delim_sel = 3'd5; end
            ";": begin mode = clts_pkg::MODE_DELIM; delim_sel = 3'd6; end
            ",": begin mode = clts_pkg::MODE_DELIM; delim_sel = 3'd7; end
            default: mode = clts_pkg::KIND_ERROR;
        endcase
    endtask

    function automatic logic [5:0] pending_kind();
        return (mode == clts_pkg::MODE_DELIM) ? clts_pkg::MODE_DELIM + {3'd0, delim_sel}
                                              : mode;
    endfunction

    task automatic scan_byte(input logic [7:0] c, input logic eoi);
        logic [11:0] col;
        logic        restart;
        logic [5:0]  nxt;
        restart = 1'b0;
        nxt = '0;
        col = (cur_col == 12'hFFF) ? cur_col : cur_col + 12'd1;
        if (eoi) begin
            if (mode <= clts_pkg::MODE_DELIM)
                emit(pending_kind(), tok_line, tok_col, tok_len, 1'b0);
            else if (mode == clts_pkg::MODE_DOT || mode == clts_pkg::MODE_AMP
                     || mode == clts_pkg::MODE_PIPE)
                emit(clts_pkg::KIND_ERROR, tok_line, tok_col, tok_len, 1'b0);
            else if (mode == clts_pkg::MODE_STR || mode == clts_pkg::MODE_ESC)
                emit(clts_pkg::KIND_ERROR, tok_line, tok_col, len_inc(tok_len), 1'b0);
            emit(clts_pkg::KIND_END, cur_line, col, '0, 1'b1);
            lexer_clear();
            return;
        end
        case (mode)
            clts_pkg::MODE_START: restart = 1'b1;
            clts_pkg::KIND_IDENT: if (alnum(c) || c == "_") take_byte(c); else restart = 1'b1;
            clts_pkg::KIND_INT, clts_pkg::KIND_FLOAT: begin
                if (digit(c)) take_byte(c);
                else if (c == "." && mode == clts_pkg::KIND_INT) begin
                    take_byte(c); mode = clts_pkg::MODE_DOT;
                end
                else if (alnum(c)) begin take_byte(c); mode = clts_pkg::KIND_ERROR; end
                else restart = 1'b1;
            end
            clts_pkg::MODE_DOT: begin
                take_byte(c); mode = digit(c) ? clts_pkg::KIND_FLOAT : clts_pkg::KIND_ERROR;
            end
            clts_pkg::MODE_AMP: begin
                take_byte(c); mode = (c == "&") ? clts_pkg::KIND_AND : clts_pkg::KIND_ERROR;
            end
            clts_pkg::MODE_PIPE: begin
                take_byte(c); mode = (c == "|") ? clts_pkg::KIND_OR : clts_pkg::KIND_ERROR;
            end
            clts_pkg::MODE_STR: begin
                if (c == "\"") mode = clts_pkg::KIND_STRING;
                else if (c == "\\") mode = clts_pkg::MODE_ESC;
                else if (c == clts_pkg::CH_LF) begin
                    tok_len = len_inc(tok_len); mode = clts_pkg::KIND_ERROR;
                end
                else take_byte(c);
            end
            clts_pkg::MODE_ESC: begin
                tail_alnum = 1'b0;
                if (c == "a" || c == "b" || c == "f" || c == "n" || c == "r" || c == "t"
                    || c == "v" || c == "'" || c == "\"" || c == "\\") begin
                    tok_len = len_inc(tok_len); mode = clts_pkg::MODE_STR;
                end else begin
                    tok_len = '0; mode = clts_pkg::KIND_ERROR;
                end
            end
            clts_pkg::MODE_LCOM: if (c == clts_pkg::CH_LF) mode = clts_pkg::MODE_START;
            clts_pkg::MODE_BCOM: if (c == "*") mode = clts_pkg::MODE_BSTAR;
            clts_pkg::MODE_BSTAR: begin
                if (c == "/") mode = clts_pkg::MODE_START;
                else if (c != "*") mode = clts_pkg::MODE_BCOM;
            end
            clts_pkg::KIND_ERROR: begin
                if (tail_alnum && alnum(c)) take_byte(c); else restart = 1'b1;
            end
            default: begin
                if (mode == clts_pkg::KIND_SLASH && c == "/") mode = clts_pkg::MODE_LCOM;
                else if (mode == clts_pkg::KIND_SLASH && c == "*") mode = clts_pkg::MODE_BCOM;
                else begin
                    case (mode)
                        clts_pkg::KIND_PLUS:
                            nxt = (c == "+") ? clts_pkg::KIND_INC :
                                  (c == "=") ? clts_pkg::KIND_ADDEQ : '0;
                        clts_pkg::KIND_MINUS:
                            nxt = (c == "-") ? clts_pkg::KIND_DEC :
                                  (c == "=") ? clts_pkg::KIND_SUBEQ : '0;
                        clts_pkg::KIND_STAR:   if (c == "=") nxt = clts_pkg::KIND_MULEQ;
                        clts_pkg::KIND_SLASH:  if (c == "=") nxt = clts_pkg::KIND_DIVEQ;
                        clts_pkg::KIND_PCT:    if (c == "=") nxt = clts_pkg::KIND_MODEQ;
                        clts_pkg::KIND_ASSIGN: if (c == "=") nxt = clts_pkg::KIND_EQ;
                        clts_pkg::KIND_NOT:    if (c == "=") nxt = clts_pkg::KIND_NE;
                        clts_pkg::KIND_GT:     if (c == "=") nxt = clts_pkg::KIND_GE;
                        clts_pkg::KIND_LT:     if (c == "=") nxt = clts_pkg::KIND_LE;
                        default: ;
                    endcase
                    if (nxt != '0) begin mode = nxt; take_byte(c); end
                    else restart = 1'b1;
                end
            end
        endcase
        if (restart) begin
            if (mode <= clts_pkg::MODE_DELIM)
                emit(pending_kind(), tok_line, tok_col, tok_len, 1'b0);
            open_token(c, col);
        end
        if (c == clts_pkg::CH_LF) begin
            cur_line = (cur_line == 16'hFFFF) ? cur_line : cur_line + 16'd1;
            cur_col = '0;
        end else begin
            cur_col = col;
        end
    endtask

    task automatic report(input string what, input logic [39:0] got, input logic [39:0] want);
        $display("%0t: token mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_token want;
        if (!i_rst_n) begin
            lexer_clear();
            tokens_due.delete();
            o_fail_count = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (tokens_due.size() == 0) begin
                    report("unexpected beat kind", 40'(m_axis_tuser), 40'd0);
                end else begin
                    want = tokens_due.pop_front();
                    if (m_axis_tuser !== want.kind) report("kind", m_axis_tuser, want.kind);
                    if (m_axis_tdata[15:0] !== want.line)
                        report("line", m_axis_tdata[15:0], want.line);
                    if (m_axis_tdata[27:16] !== want.column)
                        report("column", m_axis_tdata[27:16], want.column);
                    if (m_axis_tdata[35:28] !== want.length)
                        report("length", m_axis_tdata[35:28], want.length);
                    if (m_axis_tlast !== want.last) report("last", m_axis_tlast, want.last);
                end
            end
            // Prediction after the pop so a same-edge result cannot be mistaken.
            if (s_axis_tvalid && s_axis_tready) scan_byte(s_axis_tdata, s_axis_tuser);
        end
        o_pending = tokens_due.size();
    end

endmodule

// ===== tb/c_like_token_scanner_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c_like_token_scanner_core_tb: top of the token scanner testbench
// Sends directed source fragments, then random token-shaped text and noise,
// with random gaps on input and random back-pressure on output.
// ----------------------------------------------------------------------------
module c_like_token_scanner_core_tb;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;   // ch
    logic        s_axis_tuser = 1'b0; // end_of_input
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;        // start_line, start_column, lexeme_length
    logic [5:0]  m_axis_tuser;        // token_kind
    logic        m_axis_tlast;
    int          fail_count;
    int          pending;
    int          sent;

    always #10 i_clk = ~i_clk;

    c_like_token_scanner_core uut (.*);

    c_like_token_scanner_core_checker checker_i (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Output back-pressure, with long stretches of steady ready.
    initial begin
        int n;
        forever begin
            n = gap_len();
            repeat (n) @(posedge i_clk) m_axis_tready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk) m_axis_tready <= 1'b1;
        end
    end

    task automatic send_beat(input logic [7:0] c, input logic eoi);
        int n;
        n = gap_len();
        if (n > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= c;
        s_axis_tuser <= eoi;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_beat(s[i], 1'b0);
    endtask

    function automatic string rand_word();
        string pool[] = '{"abc", "_x9", "123", "4.56", "7.", "12ab", "\"hi\"",
            "\"a\\nb\"", "\"q\\zq\"", "\"open\n", "// c\n", "/* b ** */", "&&", "||",
            "&x", "|y", "++", "--", "+=", "-=", "*=", "/=", "%=", "==", "!=", ">=",
            "<=", "?", ":", "(", ")", "[", "]", "{", "}", ";", ",", "+", "-", "*",
            "/", "%", "=", "!", ">", "<", "#x", ".", "'", " ", "\t", "\r", "\n"};
        return pool[$urandom_range(0, pool.size() - 1)];
    endfunction

    initial begin
        int k;
        sent = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_beat(8'h00, 1'b1);
        send_text("a_1 += 12.5*x--;\n\"s\\t\\\"\"/*c*/");
        send_beat(8'hFF, 1'b0);
        send_text("3.x 9a& |\t$q1");
        send_beat(8'h80, 1'b1);
        send_text("\"un");
        send_beat(8'h55, 1'b1);
        send_text("/* open");
        send_beat(8'hAA, 1'b1);
        // A long identifier saturates its length.
        for (int i = 0; i < 300; i++) send_beat("z", 1'b0);
        send_beat(8'h00, 1'b1);
        while (sent < 550) begin
            k = $urandom_range(0, 99);
            if (k < 8) send_beat(8'($urandom_range(0, 255)), 1'b0);
            else if (k < 11) send_beat(8'($urandom_range(0, 255)), 1'b1);
            else send_text(rand_word());
        end
        send_beat(8'h00, 1'b1);
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("Regression FAIL");
        $finish;
    end

endmodule
